// File: design/sed_pkg.sv
// Package for the speech endpoint detector: widths, register defaults,
// register indexes and the sequencer state type. No dependencies.
`default_nettype none

package sed_pkg;

  localparam int MAX_FRAME_LEN_DEF = 4096;

  localparam int SAMPLE_W     = 16;
  localparam int FRAME_LEN_W  = 13;
  localparam int RATE_W       = 18;
  localparam int LEVEL_W      = 16;
  localparam int MS_W         = 16;
  localparam int ENERGY_W     = 43;
  localparam int UTT_W        = 24;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 18;

  localparam int MUL_A_W      = 32;
  localparam int MUL_B_W      = 24;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int DIVIDEND_W   = 34;
  localparam int DIV_CNT_W    = $clog2(DIVIDEND_W);

  localparam logic [MUL_A_W-1:0] MS_PER_SEC = MUL_A_W'(1000);

  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = FRAME_LEN_W'(512);
  localparam logic [RATE_W-1:0]      RATE_RST      = RATE_W'(16000);
  localparam logic [LEVEL_W-1:0]     LEVEL_RST     = LEVEL_W'(550);
  localparam logic [MS_W-1:0]        END_SIL_RST   = MS_W'(700);
  localparam logic [MS_W-1:0]        MIN_UTT_RST   = MS_W'(300);
  localparam logic [MS_W-1:0]        MAX_UTT_RST   = MS_W'(12000);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FRAME_LENGTH     = 3'd0,
    CFG_SAMPLE_RATE      = 3'd1,
    CFG_SILENCE_LEVEL    = 3'd2,
    CFG_END_SILENCE_MS   = 3'd3,
    CFG_MIN_UTTERANCE_MS = 3'd4,
    CFG_MAX_UTTERANCE_MS = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LEVEL,
    ST_THRESH,
    ST_FRAME_MS,
    ST_DIV_FRAME,
    ST_UPDATE,
    ST_UTT_MS,
    ST_DIV_UTT,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// File: design/speech_endpoint_detector.sv
// Top level of the speech endpoint detector: frame energy, silence timing
// and endpoint decision. Depends on sed_pkg.
`default_nettype none

// One item is one signed PCM sample; start_req_i opens capture and clears
// the counters. For a sample that ends a frame, the shared multiplier forms
// the square, the level squared, the threshold and two millisecond products,
// and the shared bit-serial divider carries out each of the two conversions
// to milliseconds. The input is ready only between items; a finished result
// waits in the output register and holds the sequencer only if a new result
// is due before the old one has been taken.
module speech_endpoint_detector #(
  parameter int MAX_FRAME_LEN = sed_pkg::MAX_FRAME_LEN_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [sed_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  wire logic [sed_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [sed_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                start_req_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     frame_silent_o,
  output logic [sed_pkg::MS_W-1:0]                 silence_ms_o,
  output logic [sed_pkg::MS_W-1:0]                 utterance_ms_o,
  output logic                                     endpointed_o
);
  import sed_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_LEN);
  localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
  localparam int LEN_W = (CNT_W > FRAME_LEN_W) ? CNT_W : FRAME_LEN_W;

  logic [FRAME_LEN_W-1:0] frame_len_q;
  logic [RATE_W-1:0]      rate_q;
  logic [LEVEL_W-1:0]     level_q;
  logic [MS_W-1:0]        end_sil_q;
  logic [MS_W-1:0]        min_utt_q;
  logic [MS_W-1:0]        max_utt_q;

  state_e state_q, state_d;

  logic                  capturing_q;
  logic [POS_W-1:0]      pos_q;
  logic [ENERGY_W-1:0]   energy_q;
  logic [MS_W-1:0]       sil_q;
  logic [UTT_W-1:0]      utt_q;
  logic [SAMPLE_W-1:0]   mag_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  silent_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [RATE_W-1:0]     rem_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;

  logic                  out_valid_q;
  logic                  frame_silent_q;
  logic [MS_W-1:0]       silence_ms_q;
  logic [MS_W-1:0]       utterance_ms_q;
  logic                  endpointed_q;

  logic                  in_acc;
  logic [SAMPLE_W-1:0]   mag;
  logic [CNT_W-1:0]      count;
  logic [LEN_W-1:0]      len_eff;
  logic                  frame_end;
  logic [RATE_W-1:0]     rate_eff;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     prod;
  logic [RATE_W:0]       rem_shift;
  logic                  rem_ge;
  logic [MS_W-1:0]       quo_sat;
  logic [MS_W:0]         sil_sum;
  logic [UTT_W:0]        utt_sum;
  logic                  done;
  logic                  out_free;

  assign in_acc   = in_valid_i && in_ready_o;
  assign mag      = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;
  assign count    = CNT_W'(pos_q) + 1'b1;
  assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (frame_len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(frame_len_q) > LEN_W'(MAX_FRAME_LEN)) begin
      len_eff = LEN_W'(MAX_FRAME_LEN);
    end else begin
      len_eff = LEN_W'(frame_len_q);
    end
  end

  assign frame_end = LEN_W'(count) >= len_eff;
  assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign rem_shift = {rem_q, quo_q[DIVIDEND_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, rate_eff};
  assign quo_sat   = (|quo_q[DIVIDEND_W-1:MS_W]) ? '1 : quo_q[MS_W-1:0];
  assign sil_sum   = {1'b0, sil_q} + {1'b0, quo_sat};
  assign utt_sum   = {1'b0, utt_q} + (UTT_W + 1)'(count);
  assign done      = (sil_q >= end_sil_q && quo_sat >= min_utt_q) || quo_sat >= max_utt_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (start_req_i || capturing_q)) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE:    state_d = frame_end ? ST_LEVEL : ST_IDLE;
      ST_LEVEL:     state_d = ST_THRESH;
      ST_THRESH:    state_d = ST_FRAME_MS;
      ST_FRAME_MS:  state_d = ST_DIV_FRAME;
      ST_DIV_FRAME: begin
        if (div_cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE:    state_d = ST_UTT_MS;
      ST_UTT_MS:    state_d = ST_DIV_UTT;
      ST_DIV_UTT: begin
        if (div_cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SQUARE: begin
        mul_a = MUL_A_W'(mag_q);
        mul_b = MUL_B_W'(mag_q);
      end
      ST_LEVEL: begin
        mul_a = MUL_A_W'(level_q);
        mul_b = MUL_B_W'(level_q);
      end
      ST_THRESH: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(count);
      end
      ST_FRAME_MS: begin
        mul_a = MS_PER_SEC;
        mul_b = MUL_B_W'(count);
      end
      ST_UTT_MS: begin
        mul_a = MS_PER_SEC;
        mul_b = utt_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= FRAME_LEN_RST;
      rate_q      <= RATE_RST;
      level_q     <= LEVEL_RST;
      end_sil_q   <= END_SIL_RST;
      min_utt_q   <= MIN_UTT_RST;
      max_utt_q   <= MAX_UTT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_FRAME_LENGTH:     frame_len_q <= cfg_data_i[FRAME_LEN_W-1:0];
        CFG_SAMPLE_RATE:      rate_q      <= cfg_data_i[RATE_W-1:0];
        CFG_SILENCE_LEVEL:    level_q     <= cfg_data_i[LEVEL_W-1:0];
        CFG_END_SILENCE_MS:   end_sil_q   <= cfg_data_i[MS_W-1:0];
        CFG_MIN_UTTERANCE_MS: min_utt_q   <= cfg_data_i[MS_W-1:0];
        CFG_MAX_UTTERANCE_MS: max_utt_q   <= cfg_data_i[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      capturing_q <= 1'b0;
      pos_q       <= '0;
      energy_q    <= '0;
      sil_q       <= '0;
      utt_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && start_req_i) begin
            capturing_q <= 1'b1;
            pos_q       <= '0;
            energy_q    <= '0;
            sil_q       <= '0;
            utt_q       <= '0;
          end
        end
        ST_SQUARE: begin
          energy_q <= energy_q + ENERGY_W'(prod[2*SAMPLE_W-1:0]);
          if (!frame_end) begin
            pos_q <= POS_W'(count);
          end
        end
        ST_FRAME_MS, ST_UTT_MS: div_cnt_q <= '0;
        ST_DIV_FRAME, ST_DIV_UTT: div_cnt_q <= div_cnt_q + 1'b1;
        ST_UPDATE: begin
          sil_q <= silent_q ? (sil_sum[MS_W] ? '1 : sil_sum[MS_W-1:0]) : '0;
          utt_q <= utt_sum[UTT_W] ? '1 : utt_sum[UTT_W-1:0];
        end
        ST_FINISH: begin
          if (out_free) begin
            pos_q    <= '0;
            energy_q <= '0;
            if (done) begin
              capturing_q <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mag_q <= mag;
        end
      end
      ST_LEVEL, ST_THRESH: prod_q <= prod;
      ST_FRAME_MS, ST_UTT_MS: begin
        if (state_q == ST_FRAME_MS) begin
          silent_q <= PROD_W'(energy_q) < prod_q;
        end
        quo_q <= prod[DIVIDEND_W-1:0];
        rem_q <= '0;
      end
      ST_DIV_FRAME, ST_DIV_UTT: begin
        if (rem_ge) begin
          rem_q <= RATE_W'(rem_shift - {1'b0, rate_eff});
        end else begin
          rem_q <= rem_shift[RATE_W-1:0];
        end
        quo_q <= {quo_q[DIVIDEND_W-2:0], rem_ge};
      end
      ST_FINISH: begin
        if (out_free) begin
          frame_silent_q <= silent_q;
          silence_ms_q   <= sil_q;
          utterance_ms_q <= quo_sat;
          endpointed_q   <= done;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign frame_silent_o = frame_silent_q;
  assign silence_ms_o   = silence_ms_q;
  assign utterance_ms_o = utterance_ms_q;
  assign endpointed_o   = endpointed_q;

endmodule

`default_nettype wire
